// ===== hw/rtl/lru_cache_with_pinned_entries_defines.svh =====
// assertion macros shared by the cache modules
// expects clk and rst in scope at the point of use
`ifndef LRU_CACHE_WITH_PINNED_ENTRIES_DEFINES_SVH
`define LRU_CACHE_WITH_PINNED_ENTRIES_DEFINES_SVH

// checked only outside reset
`define LCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define LCP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lcp_pkg.sv =====
// shared types and constants for the lru cache with pinned entries
// no dependencies
package lcp_pkg;

  localparam int LCP_CAPACITY = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] entry_key;
    logic [31:0] payload_handle;
    logic        pin_flag;
  } req_t;

  typedef struct packed {
    logic        success;
    logic        was_present;
    logic [31:0] handle_out;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming word
    logic match;   // register the per-slot key compare
    logic commit;  // apply the update and write the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } status_t;

endpackage

// ===== hw/rtl/lcp_datapath.sv =====
// slot table, key compare, eviction select, shift compaction and result register
// depends on lcp_pkg and the assertion macro header
`include "lru_cache_with_pinned_entries_defines.svh"

module lcp_datapath import lcp_pkg::*; #(
  parameter int CAPACITY = LCP_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    in_data,
  input  logic    out_ready,
  input  cmd_t    cmd,
  output status_t status,
  output logic    out_valid,
  output rsp_t    out_data
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int FW   = $clog2(CAPACITY + 1);

  req_t          req;
  logic [FW-1:0] fill_count;

  // entry storage, oldest in slot 0
  logic [63:0] slot_keys    [CAPACITY];
  logic [31:0] slot_handles [CAPACITY];
  logic        slot_pinned  [CAPACITY];

  logic [CAPACITY-1:0] slot_valid;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] unpinned;
  logic [CAPACITY-1:0] sel;
  logic [CAPACITY-1:0] sel_ge;     // slot at or above the selected one
  logic [CAPACITY-1:0] sel_first;

  logic            hit;
  logic            full;
  logic            any_unpinned;
  logic            is_add;
  logic            do_remove;
  logic            do_append;
  logic [31:0]     sel_handle;
  logic            sel_pin;
  logic [31:0]     app_handle;
  logic            app_pin;
  logic [FW-1:0]   fill_m1;
  logic [IDXW-1:0] app_pos;
  rsp_t            rsp;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_valid[i] = FW'(i) < fill_count;
    end
  end

  // compare against every live slot in parallel
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match[i] <= slot_valid[i] && (slot_keys[i] == req.entry_key);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      unpinned[i] = slot_valid[i] && !slot_pinned[i];
    end
  end

  assign hit          = |match;
  assign full         = fill_count == FW'(CAPACITY);
  assign any_unpinned = |unpinned;
  assign sel          = hit ? match : unpinned;

  // thermometer from the lowest selected slot, each bit on its own
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      sel_ge[i] = |(sel & ((CAPACITY)'(2) << i) - (CAPACITY)'(1)) ;
    end
    sel_first[0] = sel[0];
    for (int i = 1; i < CAPACITY; i++) begin
      sel_first[i] = sel[i] && !sel_ge[i-1];
    end
  end

  always_comb begin
    sel_handle = '0;
    sel_pin    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_handle = sel_handle | (slot_handles[i] & {32{sel_first[i]}});
      sel_pin    = sel_pin | (slot_pinned[i] & sel_first[i]);
    end
  end

  assign is_add     = req.operation == OP_ADD;
  assign do_remove  = hit || (full && any_unpinned);
  assign do_append  = hit || !full || any_unpinned;
  assign app_handle = hit ? sel_handle : req.payload_handle;
  assign app_pin    = hit ? sel_pin : req.pin_flag;
  assign fill_m1    = fill_count - FW'(1);
  assign app_pos    = do_remove ? fill_m1[IDXW-1:0] : fill_count[IDXW-1:0];

  // shift newer entries down over the removed one, then place the entry on top
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    logic [63:0] up_key;
    logic [31:0] up_handle;
    logic        up_pin;

    if (g == CAPACITY - 1) begin : g_top
      assign up_key    = slot_keys[g];
      assign up_handle = slot_handles[g];
      assign up_pin    = slot_pinned[g];
    end else begin : g_mid
      assign up_key    = slot_keys[g+1];
      assign up_handle = slot_handles[g+1];
      assign up_pin    = slot_pinned[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.commit && is_add && do_append) begin
        if (app_pos == IDXW'(g)) begin
          slot_keys[g]    <= req.entry_key;
          slot_handles[g] <= app_handle;
          slot_pinned[g]  <= app_pin;
        end else if (do_remove && sel_ge[g]) begin
          slot_keys[g]    <= up_key;
          slot_handles[g] <= up_handle;
          slot_pinned[g]  <= up_pin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.commit) begin
      if (req.operation == OP_CLEAR) begin
        fill_count <= '0;
      end else if (is_add && do_append && !do_remove) begin
        fill_count <= fill_count + FW'(1);
      end
    end
  end

  always_comb begin
    rsp = '0;
    case (req.operation)
      OP_ADD: begin
        rsp.success     = do_append;
        rsp.was_present = hit;
      end
      OP_LOOKUP: begin
        rsp.success     = hit;
        rsp.was_present = hit;
        rsp.handle_out  = hit ? sel_handle : '0;
      end
      OP_CLEAR: begin
        rsp.success = 1'b1;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  `LCP_ASSERT(a_fill_bound, fill_count <= FW'(CAPACITY), "fill count above capacity")
  `LCP_ASSERT(a_commit_room, cmd.commit |-> (!out_valid || out_ready), "result overwritten")
  `LCP_ASSERT(a_clear_empties, (cmd.commit && req.operation == OP_CLEAR) |=> fill_count == '0,
    "clear left entries")
  `LCP_ASSERT(a_fill_step, !cmd.commit |=> $stable(fill_count), "fill changed without commit")

endmodule

// ===== hw/rtl/lcp_ctrl.sv =====
// request sequencer: accept, compare, update and hand the result to the output register
// depends on lcp_pkg and the assertion macro header
`include "lru_cache_with_pinned_entries_defines.svh"

module lcp_ctrl import lcp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_MATCH;
      end
      S_MATCH: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.out_free) state_next = accept ? S_MATCH : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // a new word may enter in the same cycle the previous one commits
  always_comb begin
    in_ready   = 1'b0;
    cmd.match  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
      end
      S_MATCH: begin
        cmd.match = 1'b1;
      end
      S_UPDATE: begin
        cmd.commit = status.out_free;
        in_ready   = status.out_free && !rst;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = in_valid && in_ready;
  end

  `LCP_ASSERT(a_accept_to_match, (in_valid && in_ready) |=> state == S_MATCH,
    "accepted word not compared")
  `LCP_ASSERT(a_match_to_update, state == S_MATCH |=> state == S_UPDATE, "compare not followed")
  `LCP_ASSERT(a_commit_in_update, cmd.commit |-> state == S_UPDATE, "commit outside update")

endmodule

// ===== hw/rtl/lru_cache_with_pinned_entries.sv =====
// lru cache with pinned entries: top level
// depends on lcp_pkg, lcp_ctrl and lcp_datapath
//
// Request channel in_valid/in_ready/in_data carries one word: add, lookup,
// clear or no-op with key, handle and pin flag. Response channel
// out_valid/out_ready/out_data returns exactly one word per request, in order.
// An accepted request is registered, compared against all slots in the match
// step and committed in the update step once the output register is free; a
// new request can be taken in the same cycle the previous one commits. The
// update step applies the registered parallel key compare through the
// eviction select and shift compaction of the slot table.
// The response sits in an output register; a request may be accepted while it
// waits. If the receiver stalls, the next request holds in its update step
// until the register drains, and in_ready stays low meanwhile.
// Reset empties the table (fill count to zero) and drops any pending response;
// no clearing pass is needed since slots above the fill count are never read.
module lru_cache_with_pinned_entries import lcp_pkg::*; #(
  parameter int CAPACITY = LCP_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  cmd_t    cmd;
  status_t status;

  lcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lcp_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
